// File: hdl/lrsp_pkg.sv
`default_nettype none
package lrsp_pkg;

	localparam int MAP_WORDS = 9;
	localparam int MAP_SLOTS = MAP_WORDS * 32;
	localparam int SLOT_W = $clog2(MAP_SLOTS + 1);

	localparam int OP_W = 2;
	localparam int SEED_W = 32;
	localparam int COUNT_W = 9;
	localparam int STEP_W = 16;
	localparam int RESULT_W = 32;

	localparam int PROD_W = 48;
	localparam int MUL_W = 16;
	localparam logic [MUL_W-1:0] LEHMER_MUL = MUL_W'(48271);
	localparam logic [31:0] MASK31 = 32'h7fff_ffff;
	localparam logic [31:0] SEED_BIT = 32'h0000_8000;
	localparam int GUARD_W = 11;
	localparam logic [GUARD_W-1:0] SKIP_LIMIT = GUARD_W'(1024);
	localparam logic [COUNT_W-1:0] SKIP_MIN_COUNT = COUNT_W'(4);
	localparam int DIV_CNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_SEED = 2'd0,
		OP_NEXT = 2'd1,
		OP_SHUF = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MS_STATE,
		MS_SEED,
		MS_R
	} mul_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STATE_MUL,
		ST_STATE_FOLD,
		ST_RED,
		ST_RED_MUL,
		ST_RED_FOLD,
		ST_SKIP_MUL,
		ST_SKIP_FOLD,
		ST_SKIP_DIV,
		ST_SKIP_CHK,
		ST_DRAW_MUL,
		ST_DRAW_FOLD,
		ST_DRAW_DIV,
		ST_WALK_INIT,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic     accept;
		logic     mul_en;
		mul_src_t mul_src;
		logic     fold_to_state;
		logic     fold_to_r;
		logic     fold_to_t;
		logic     div_load;
		logic     div_by_count;
		logic     div_step;
		logic     red_sub;
		logic     skip_take;
		logic     walk_init;
		logic     walk_step;
		logic     draw_next;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic bad;
		logic step_ge;
		logic count_ge4;
		logic div_done;
		logic skip_hit;
		logic walk_found;
		logic step_zero;
	} status_t;

	function automatic logic [31:0] lehmer_fold(input logic [PROD_W-1:0] p);
		logic [31:0] y;
		y = 32'(p[30:0]) + 32'(p[PROD_W-1:31]);
		return 32'(y[30:0]) + 32'(y[31]);
	endfunction

endpackage
`default_nettype wire

// File: hdl/lrsp_req_if.sv
`default_nettype none
interface lrsp_req_if;
	logic                            valid;
	logic                            ready;
	logic [lrsp_pkg::OP_W-1:0]       opcode;
	logic [lrsp_pkg::SEED_W-1:0]     seed_value;
	logic [lrsp_pkg::COUNT_W-1:0]    item_count;
	logic [lrsp_pkg::STEP_W-1:0]     play_step;

	modport source (output valid, opcode, seed_value, item_count, play_step, input ready);
	modport sink (input valid, opcode, seed_value, item_count, play_step, output ready);
endinterface
`default_nettype wire

// File: hdl/lrsp_rsp_if.sv
`default_nettype none
interface lrsp_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [lrsp_pkg::RESULT_W-1:0]   result_value;
	logic                            bad_count;

	modport source (output valid, result_value, bad_count, input ready);
	modport sink (input valid, result_value, bad_count, output ready);
endinterface
`default_nettype wire

// File: hdl/lrsp_datapath.sv
`default_nettype none
module lrsp_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire lrsp_pkg::cmd_t              cmd,
	output lrsp_pkg::status_t                status,
	input  wire [lrsp_pkg::OP_W-1:0]         opcode,
	input  wire [lrsp_pkg::SEED_W-1:0]       seed_value,
	input  wire [lrsp_pkg::COUNT_W-1:0]      item_count,
	input  wire [lrsp_pkg::STEP_W-1:0]       play_step,
	output logic [lrsp_pkg::RESULT_W-1:0]    result_value,
	output logic                             bad_count
);

	logic [31:0]                       state_q;
	logic [31:0]                       r_q;
	logic [31:0]                       t_q;
	logic [31:0]                       seed_q;
	lrsp_pkg::op_t                     op_q;
	logic [lrsp_pkg::COUNT_W-1:0]      count_q;
	logic [lrsp_pkg::COUNT_W-1:0]      remc_q;
	logic [lrsp_pkg::STEP_W-1:0]       step_q;
	logic [lrsp_pkg::GUARD_W-1:0]      guard_q;
	logic [lrsp_pkg::PROD_W-1:0]       prod_s1;
	logic [31:0]                       fold;
	logic [31:0]                       mul_in;
	logic [31:0]                       dv_q;
	logic [lrsp_pkg::COUNT_W-1:0]      dsr_q;
	logic [lrsp_pkg::COUNT_W-1:0]      rm_q;
	logic [lrsp_pkg::DIV_CNT_W-1:0]    dcnt_q;
	logic [lrsp_pkg::COUNT_W:0]        div_tmp;
	logic [lrsp_pkg::MAP_SLOTS-1:0]    map_q;
	logic [lrsp_pkg::SLOT_W-1:0]       v_q;
	logic [lrsp_pkg::COUNT_W-1:0]      k_q;
	logic                              slot_busy;
	logic [31:0]                       result_q;
	logic                              bad_q;

	assign fold = lrsp_pkg::lehmer_fold(prod_s1);

	always_comb begin
		case (cmd.mul_src)
			lrsp_pkg::MS_SEED: mul_in = ((state_q + seed_q) | lrsp_pkg::SEED_BIT) & lrsp_pkg::MASK31;
			lrsp_pkg::MS_R:    mul_in = r_q;
			default:           mul_in = state_q;
		endcase
	end

	assign div_tmp = {rm_q, dv_q[31]};
	assign slot_busy = (v_q < lrsp_pkg::SLOT_W'(lrsp_pkg::MAP_SLOTS)) ?
		map_q[v_q[$clog2(lrsp_pkg::MAP_SLOTS)-1:0]] : 1'b0;

	always_comb begin
		status.op         = op_q;
		status.bad        = (count_q == '0) ||
			(32'(count_q) >= 32'(lrsp_pkg::MAP_SLOTS));
		status.step_ge    = step_q >= lrsp_pkg::STEP_W'(count_q);
		status.count_ge4  = count_q >= lrsp_pkg::SKIP_MIN_COUNT;
		status.div_done   = dcnt_q == '1;
		status.skip_hit   = (rm_q == '0) && (guard_q < lrsp_pkg::SKIP_LIMIT);
		status.walk_found = !slot_busy && (k_q == '0);
		status.step_zero  = step_q == '0;
	end

	// generator state is the only register with a defined reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.fold_to_state) begin
			state_q <= fold;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= lrsp_pkg::op_t'(opcode);
			seed_q   <= seed_value;
			count_q  <= item_count;
			remc_q   <= item_count;
			step_q   <= play_step;
			r_q      <= state_q;
			guard_q  <= '0;
			map_q    <= '0;
			result_q <= '0;
			bad_q    <= (opcode == lrsp_pkg::OP_SHUF) && ((item_count == '0) ||
				(32'(item_count) >= 32'(lrsp_pkg::MAP_SLOTS)));
		end
		if (cmd.mul_en) begin
			prod_s1 <= lrsp_pkg::PROD_W'(mul_in) * lrsp_pkg::PROD_W'(lrsp_pkg::LEHMER_MUL);
		end
		if (cmd.fold_to_state) begin
			result_q <= fold;
		end
		if (cmd.fold_to_r) begin
			r_q <= fold;
		end
		if (cmd.fold_to_t) begin
			t_q <= fold;
		end
		if (cmd.red_sub) begin
			step_q <= step_q - lrsp_pkg::STEP_W'(count_q);
		end
		if (cmd.skip_take) begin
			r_q     <= t_q;
			guard_q <= guard_q + 1'b1;
		end
		// restoring remainder, one dividend bit per cycle
		if (cmd.div_load) begin
			dv_q   <= fold;
			dsr_q  <= cmd.div_by_count ? count_q : remc_q;
			rm_q   <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dv_q   <= {dv_q[30:0], 1'b0};
			dcnt_q <= dcnt_q + 1'b1;
			if (div_tmp >= {1'b0, dsr_q}) begin
				rm_q <= lrsp_pkg::COUNT_W'(div_tmp - {1'b0, dsr_q});
			end else begin
				rm_q <= div_tmp[lrsp_pkg::COUNT_W-1:0];
			end
		end
		// slot walk: skip used slots, count down free ones
		if (cmd.walk_init) begin
			v_q <= '0;
			k_q <= rm_q;
		end else if (cmd.walk_step) begin
			if (slot_busy) begin
				v_q <= v_q + 1'b1;
			end else if (k_q == '0) begin
				if (v_q < lrsp_pkg::SLOT_W'(lrsp_pkg::MAP_SLOTS)) begin
					map_q[v_q[$clog2(lrsp_pkg::MAP_SLOTS)-1:0]] <= 1'b1;
				end
				result_q <= 32'(v_q);
			end else begin
				k_q <= k_q - 1'b1;
				v_q <= v_q + 1'b1;
			end
		end
		if (cmd.draw_next) begin
			step_q <= step_q - 1'b1;
			remc_q <= remc_q - 1'b1;
		end
	end

	assign result_value = result_q;
	assign bad_count    = bad_q;

endmodule
`default_nettype wire

// File: hdl/lrsp_ctrl.sv
`default_nettype none
module lrsp_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  wire lrsp_pkg::status_t status,
	output lrsp_pkg::cmd_t         cmd
);

	lrsp_pkg::state_t state_q, state_nxt;
	logic             out_q, out_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrsp_pkg::ST_IDLE;
			out_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			out_q   <= out_nxt;
		end
	end

	// result hold is folded into ST_IDLE with out_q set
	always_comb begin
		state_nxt = state_q;
		out_nxt   = out_q;
		case (state_q)
			lrsp_pkg::ST_IDLE: begin
				if (out_q) begin
					if (out_ready) out_nxt = 1'b0;
				end else if (in_valid) begin
					state_nxt = lrsp_pkg::ST_DECODE;
				end
			end
			lrsp_pkg::ST_DECODE: begin
				case (status.op)
					lrsp_pkg::OP_SEED, lrsp_pkg::OP_NEXT: state_nxt = lrsp_pkg::ST_STATE_MUL;
					lrsp_pkg::OP_SHUF: begin
						if (status.bad) begin
							state_nxt = lrsp_pkg::ST_IDLE;
							out_nxt   = 1'b1;
						end else begin
							state_nxt = lrsp_pkg::ST_RED;
						end
					end
					default: begin
						state_nxt = lrsp_pkg::ST_IDLE;
						out_nxt   = 1'b1;
					end
				endcase
			end
			lrsp_pkg::ST_STATE_MUL:  state_nxt = lrsp_pkg::ST_STATE_FOLD;
			lrsp_pkg::ST_STATE_FOLD: begin
				state_nxt = lrsp_pkg::ST_IDLE;
				out_nxt   = 1'b1;
			end
			lrsp_pkg::ST_RED: begin
				if (status.step_ge) state_nxt = lrsp_pkg::ST_RED_MUL;
				else if (status.count_ge4) state_nxt = lrsp_pkg::ST_SKIP_MUL;
				else state_nxt = lrsp_pkg::ST_DRAW_MUL;
			end
			lrsp_pkg::ST_RED_MUL:   state_nxt = lrsp_pkg::ST_RED_FOLD;
			lrsp_pkg::ST_RED_FOLD:  state_nxt = lrsp_pkg::ST_RED;
			lrsp_pkg::ST_SKIP_MUL:  state_nxt = lrsp_pkg::ST_SKIP_FOLD;
			lrsp_pkg::ST_SKIP_FOLD: state_nxt = lrsp_pkg::ST_SKIP_DIV;
			lrsp_pkg::ST_SKIP_DIV:  if (status.div_done) state_nxt = lrsp_pkg::ST_SKIP_CHK;
			lrsp_pkg::ST_SKIP_CHK: begin
				state_nxt = status.skip_hit ? lrsp_pkg::ST_SKIP_MUL : lrsp_pkg::ST_DRAW_MUL;
			end
			lrsp_pkg::ST_DRAW_MUL:  state_nxt = lrsp_pkg::ST_DRAW_FOLD;
			lrsp_pkg::ST_DRAW_FOLD: state_nxt = lrsp_pkg::ST_DRAW_DIV;
			lrsp_pkg::ST_DRAW_DIV:  if (status.div_done) state_nxt = lrsp_pkg::ST_WALK_INIT;
			lrsp_pkg::ST_WALK_INIT: state_nxt = lrsp_pkg::ST_WALK;
			lrsp_pkg::ST_WALK: begin
				if (status.walk_found) begin
					if (status.step_zero) begin
						state_nxt = lrsp_pkg::ST_IDLE;
						out_nxt   = 1'b1;
					end else begin
						state_nxt = lrsp_pkg::ST_DRAW_MUL;
					end
				end
			end
			default: state_nxt = lrsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_src   = lrsp_pkg::MS_R;
		in_ready      = (state_q == lrsp_pkg::ST_IDLE) && !out_q;
		out_valid     = (state_q == lrsp_pkg::ST_IDLE) && out_q;
		case (state_q)
			lrsp_pkg::ST_IDLE:       cmd.accept = in_valid && !out_q;
			lrsp_pkg::ST_STATE_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_src = (status.op == lrsp_pkg::OP_SEED) ?
					lrsp_pkg::MS_SEED : lrsp_pkg::MS_STATE;
			end
			lrsp_pkg::ST_STATE_FOLD: cmd.fold_to_state = 1'b1;
			lrsp_pkg::ST_RED:        cmd.red_sub = status.step_ge;
			lrsp_pkg::ST_RED_MUL:    cmd.mul_en = 1'b1;
			lrsp_pkg::ST_RED_FOLD:   cmd.fold_to_r = 1'b1;
			lrsp_pkg::ST_SKIP_MUL:   cmd.mul_en = 1'b1;
			lrsp_pkg::ST_SKIP_FOLD: begin
				cmd.fold_to_t    = 1'b1;
				cmd.div_load     = 1'b1;
				cmd.div_by_count = 1'b1;
			end
			lrsp_pkg::ST_SKIP_DIV:   cmd.div_step = 1'b1;
			lrsp_pkg::ST_SKIP_CHK:   cmd.skip_take = status.skip_hit;
			lrsp_pkg::ST_DRAW_MUL:   cmd.mul_en = 1'b1;
			lrsp_pkg::ST_DRAW_FOLD: begin
				cmd.fold_to_r = 1'b1;
				cmd.div_load  = 1'b1;
			end
			lrsp_pkg::ST_DRAW_DIV:   cmd.div_step = 1'b1;
			lrsp_pkg::ST_WALK_INIT:  cmd.walk_init = 1'b1;
			lrsp_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.draw_next = status.walk_found && !status.step_zero;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/lehmer_rng_shuffle_picker.sv
`default_nettype none
// Lehmer (x48271 mod 2^31-1) generator with a shuffle picker. One transaction in gives
// one transaction out; one item is worked at a time and req.ready stays low from
// acceptance until the cycle after the result has been taken. Seed and next pass
// through decode, multiply and fold before presenting their result. Shuffle runs on one
// 32x16 multiplier and a one-bit-per-cycle remainder unit. Each advance is a multiply
// state and then a fold state. A remainder is followed by a check state in a skip test
// and by the slot walk in a draw, which visits one map bit per cycle. Bad counts return
// right after the decode cycle.
module lehmer_rng_shuffle_picker (
	input  wire      clk,
	input  wire      arst_n,
	lrsp_req_if.sink   req,
	lrsp_rsp_if.source rsp
);

	lrsp_pkg::cmd_t    cmd;
	lrsp_pkg::status_t status;

	lrsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lrsp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.opcode       (req.opcode),
		.seed_value   (req.seed_value),
		.item_count   (req.item_count),
		.play_step    (req.play_step),
		.result_value (rsp.result_value),
		.bad_count    (rsp.bad_count)
	);

endmodule
`default_nettype wire
